@@ sv/ais_pkg.sv @@
// Shared widths, command codes, divider handshake types and character helpers
// for the alignment identity scorer. No dependencies.
package ais_pkg;

    localparam int FIELD_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int CMD_W          = 2;
    localparam int ID_W           = 8;
    localparam int COV_W          = 7;
    localparam int CNT_W          = 32;
    localparam int TOT_W          = 40;
    localparam int PROD_W         = 48;
    localparam int DIV_NUM_W      = 50;
    localparam int DIV_DEN_W      = TOT_W + 1;
    localparam int COORD_BITS_DEF = 32;

    localparam int MUL_ID_LEN  = 100;
    localparam int MUL_ID_EDIT = 200;
    localparam int MUL_COV     = 200;
    localparam int PCT_FULL    = 100;
    localparam int PCT_CAP     = 99;

    localparam logic [CMD_W-1:0] CMD_COLUMN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXON   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [CHAR_W-1:0] CH_N_UP  = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_N_LO  = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_GAP   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] f_upper(input logic [CHAR_W-1:0] c);
        return (c >= CH_A_LO && c <= CH_Z_LO) ? (c - CASE_BIT) : c;
    endfunction

    function automatic logic [CHAR_W-1:0] f_lower(input logic [CHAR_W-1:0] c);
        return (c >= CH_A_UP && c <= CH_Z_UP) ? (c + CASE_BIT) : c;
    endfunction

    // base set as a 4-bit mask: A=1 C=2 G=4 T/U=8, zero for N and for non-IUPAC characters
    function automatic logic [3:0] f_iupac(input logic [CHAR_W-1:0] c);
        logic [3:0] bits;
        case (f_upper(c))
            8'h41:        bits = 4'd1;   // A
            8'h43:        bits = 4'd2;   // C
            8'h47:        bits = 4'd4;   // G
            8'h54, 8'h55: bits = 4'd8;   // T U
            8'h52:        bits = 4'd5;   // R
            8'h59:        bits = 4'd10;  // Y
            8'h53:        bits = 4'd6;   // S
            8'h57:        bits = 4'd9;   // W
            8'h4B:        bits = 4'd12;  // K
            8'h4D:        bits = 4'd3;   // M
            8'h42:        bits = 4'd14;  // B
            8'h44:        bits = 4'd13;  // D
            8'h48:        bits = 4'd11;  // H
            8'h56:        bits = 4'd7;   // V
            default:      bits = 4'd0;
        endcase
        return bits;
    endfunction

    function automatic logic [CNT_W-1:0] f_sat32(input logic [TOT_W-1:0] v);
        return (v[TOT_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : v[CNT_W-1:0];
    endfunction

endpackage

@@ sv/ais_if.sv @@
// Command and result channel interfaces (valid/ready plus payload).
// Depends on ais_pkg for field widths.
interface ais_cmd_if;
    import ais_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CHAR_W-1:0]    est_char;
    logic [CHAR_W-1:0]    gen_char;
    logic [FIELD_W-1:0]   gen_start;
    logic [FIELD_W-1:0]   gen_end;
    logic [FIELD_W-1:0]   query_start;
    logic [FIELD_W-1:0]   query_end;
    logic [FIELD_W-1:0]   query_length;
    logic [FIELD_W-1:0]   poly_a_length;
    logic [FIELD_W-1:0]   poly_t_length;

    modport source (
        output valid, command, est_char, gen_char, gen_start, gen_end,
               query_start, query_end, query_length, poly_a_length, poly_t_length,
        input  ready
    );
    modport sink (
        input  valid, command, est_char, gen_char, gen_start, gen_end,
               query_start, query_end, query_length, poly_a_length, poly_t_length,
        output ready
    );
endinterface

interface ais_res_if;
    import ais_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        result_kind;
    logic [CHAR_W-1:0]       est_out;
    logic [CHAR_W-1:0]       gen_out;
    logic [CNT_W-1:0]        match_count;
    logic [CNT_W-1:0]        both_n_count;
    logic signed [ID_W-1:0]  identity_percent;
    logic [CNT_W-1:0]        covered_count;
    logic [COV_W-1:0]        coverage_percent;

    modport source (
        output valid, result_kind, est_out, gen_out, match_count, both_n_count,
               identity_percent, covered_count, coverage_percent,
        input  ready
    );
    modport sink (
        input  valid, result_kind, est_out, gen_out, match_count, both_n_count,
               identity_percent, covered_count, coverage_percent,
        output ready
    );
endinterface

@@ sv/ais_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ais_pkg (t_div_req / t_div_rsp, widths).
module ais_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ais_pkg::t_div_req i_req,
    output ais_pkg::t_div_rsp o_rsp
);
    import ais_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_NUM_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_q, n_q;
    logic [DIV_DEN_W-1:0] r_den, n_den;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // dividend bits leave r_q at the top while quotient bits enter at the bottom
    assign w_shift = {r_rem, r_q[DIV_NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            n_q   = {r_q[DIV_NUM_W-2:0], w_ge};
            n_cnt = r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(DIV_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

@@ sv/alignment_identity_scorer_core.sv @@
// Alignment identity scorer. A column-pair beat is classified on acceptance and answered
// in the next cycle whenever the result register is free. Exon-end and record-end beats
// are sequenced around the shared 50-step restoring divider (a pass for identity,
// a second for coverage on record end, each skipped when a special case settles
// the result), with sequencer steps for spans, constant scaling and sign handling
// around it. The command channel is held off while an end beat is in progress. One
// result beat per command 0, 1 or 2; command 3 is consumed silently.
module alignment_identity_scorer_core #(
    parameter int COORD_BITS = ais_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ais_cmd_if.sink   i_cmd,
    ais_res_if.source o_res
);
    import ais_pkg::*;

    localparam int CW     = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SPAN_W = CW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SPAN     = 4'd1;
    localparam logic [3:0] S_LEN      = 4'd2;
    localparam logic [3:0] S_ID_MUL   = 4'd3;
    localparam logic [3:0] S_ID_SUB   = 4'd4;
    localparam logic [3:0] S_ID_LD    = 4'd5;
    localparam logic [3:0] S_ID_WAIT  = 4'd6;
    localparam logic [3:0] S_COV_D1   = 4'd7;
    localparam logic [3:0] S_COV_D2   = 4'd8;
    localparam logic [3:0] S_COV_CHK  = 4'd9;
    localparam logic [3:0] S_COV_LD   = 4'd10;
    localparam logic [3:0] S_COV_WAIT = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    // control and model state
    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_exon_edits, n_exon_edits;
    logic [CNT_W-1:0]  r_exon_matches, n_exon_matches;
    logic [CNT_W-1:0]  r_exon_both_n, n_exon_both_n;
    logic [TOT_W-1:0]  r_tot_edits, n_tot_edits;
    logic [TOT_W-1:0]  r_tot_matches, n_tot_matches;
    logic [TOT_W-1:0]  r_tot_both_n, n_tot_both_n;
    logic [TOT_W-1:0]  r_tot_len, n_tot_len;
    logic [TOT_W-1:0]  r_tot_cov, n_tot_cov;
    logic              r_o_valid, n_o_valid;

    // working registers
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [CW-1:0]     r_c0, n_c0;
    logic [CW-1:0]     r_c1, n_c1;
    logic [CW-1:0]     r_c2, n_c2;
    logic [CW-1:0]     r_c3, n_c3;
    logic [SPAN_W-1:0] r_gs, n_gs;
    logic [SPAN_W-1:0] r_qs, n_qs;
    logic [TOT_W-1:0]  r_l, n_l;
    logic [TOT_W-1:0]  r_e, n_e;
    logic [PROD_W-1:0] r_a, n_a;
    logic [PROD_W-1:0] r_b, n_b;
    logic [PROD_W-1:0] r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [CW-1:0]     r_d, n_d;
    logic [ID_W-1:0]   r_id, n_id;
    logic [COV_W-1:0]  r_cov, n_cov;

    // result register
    logic [CMD_W-1:0]  r_o_kind, n_o_kind;
    logic [CHAR_W-1:0] r_o_est, n_o_est;
    logic [CHAR_W-1:0] r_o_gen, n_o_gen;
    logic [CNT_W-1:0]  r_o_match, n_o_match;
    logic [CNT_W-1:0]  r_o_both_n, n_o_both_n;
    logic [ID_W-1:0]   r_o_id, n_o_id;
    logic [CNT_W-1:0]  r_o_cov_cnt, n_o_cov_cnt;
    logic [COV_W-1:0]  r_o_cov_pct, n_o_cov_pct;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic w_o_free;
    logic w_accept;
    logic w_e_n, w_g_n, w_match;
    logic [3:0] w_after_id;

    ais_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_o_free    = !r_o_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_o_free;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_after_id  = (r_cmd == CMD_RECORD) ? S_COV_D1 : S_FIN;

    // column classification straight off the channel
    assign w_e_n   = (i_cmd.est_char == CH_N_UP) || (i_cmd.est_char == CH_N_LO);
    assign w_g_n   = (i_cmd.gen_char == CH_N_UP) || (i_cmd.gen_char == CH_N_LO);
    assign w_match = (i_cmd.est_char != CH_GAP) && (i_cmd.gen_char != CH_GAP)
                     && !w_e_n && !w_g_n
                     && ((f_iupac(i_cmd.est_char) & f_iupac(i_cmd.gen_char)) != 4'd0);

    always_comb begin
        w_div_req.start = (r_state == S_ID_LD) || (r_state == S_COV_LD);
        if (r_state == S_COV_LD) begin
            w_div_req.num = DIV_NUM_W'(r_a) + DIV_NUM_W'(r_d);
            w_div_req.den = DIV_DEN_W'({r_d, 1'b0});
        end else begin
            w_div_req.num = DIV_NUM_W'({r_mag, 1'b0}) + DIV_NUM_W'(r_l);
            w_div_req.den = DIV_DEN_W'({r_l, 1'b0});
        end
    end

    always_comb begin
        n_state        = r_state;
        n_exon_edits   = r_exon_edits;
        n_exon_matches = r_exon_matches;
        n_exon_both_n  = r_exon_both_n;
        n_tot_edits    = r_tot_edits;
        n_tot_matches  = r_tot_matches;
        n_tot_both_n   = r_tot_both_n;
        n_tot_len      = r_tot_len;
        n_tot_cov      = r_tot_cov;
        n_o_valid      = r_o_valid && !o_res.ready;
        n_cmd          = r_cmd;
        n_c0           = r_c0;
        n_c1           = r_c1;
        n_c2           = r_c2;
        n_c3           = r_c3;
        n_gs           = r_gs;
        n_qs           = r_qs;
        n_l            = r_l;
        n_e            = r_e;
        n_a            = r_a;
        n_b            = r_b;
        n_mag          = r_mag;
        n_neg          = r_neg;
        n_d            = r_d;
        n_id           = r_id;
        n_cov          = r_cov;
        n_o_kind       = r_o_kind;
        n_o_est        = r_o_est;
        n_o_gen        = r_o_gen;
        n_o_match      = r_o_match;
        n_o_both_n     = r_o_both_n;
        n_o_id         = r_o_id;
        n_o_cov_cnt    = r_o_cov_cnt;
        n_o_cov_pct    = r_o_cov_pct;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_cmd.command;
                    unique case (i_cmd.command)
                        CMD_COLUMN: begin
                            if (w_match) begin
                                if (r_exon_matches != '1) n_exon_matches = r_exon_matches + 1'b1;
                            end else if (w_e_n && w_g_n && (i_cmd.est_char != CH_GAP)
                                         && (i_cmd.gen_char != CH_GAP)) begin
                                // N on both sides (a gap already ruled out)
                                if (r_exon_both_n != '1) n_exon_both_n = r_exon_both_n + 1'b1;
                            end else begin
                                if (r_exon_edits != '1) n_exon_edits = r_exon_edits + 1'b1;
                            end
                            n_o_valid   = 1'b1;
                            n_o_kind    = CMD_COLUMN;
                            n_o_est     = w_match ? f_lower(i_cmd.est_char)
                                                  : f_upper(i_cmd.est_char);
                            n_o_gen     = w_match ? f_lower(i_cmd.gen_char)
                                                  : f_upper(i_cmd.gen_char);
                            n_o_match   = '0;
                            n_o_both_n  = '0;
                            n_o_id      = '0;
                            n_o_cov_cnt = '0;
                            n_o_cov_pct = '0;
                        end
                        CMD_EXON: begin
                            n_c0    = i_cmd.gen_start[CW-1:0];
                            n_c1    = i_cmd.gen_end[CW-1:0];
                            n_c2    = i_cmd.query_start[CW-1:0];
                            n_c3    = i_cmd.query_end[CW-1:0];
                            n_state = S_SPAN;
                        end
                        CMD_RECORD: begin
                            n_c0    = i_cmd.query_length[CW-1:0];
                            n_c1    = i_cmd.poly_a_length[CW-1:0];
                            n_c2    = i_cmd.poly_t_length[CW-1:0];
                            n_l     = r_tot_len;
                            n_e     = r_tot_edits;
                            n_state = S_ID_MUL;
                        end
                        CMD_NONE: begin
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SPAN: begin
                n_gs = (r_c1 >= r_c0) ? ({1'b0, r_c1} - {1'b0, r_c0} + SPAN_W'(1)) : '0;
                n_qs = (r_c3 >= r_c2) ? ({1'b0, r_c3} - {1'b0, r_c2} + SPAN_W'(1)) : '0;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_l     = TOT_W'(r_gs) + TOT_W'(r_qs) + TOT_W'(r_exon_edits);
                n_e     = TOT_W'(r_exon_edits);
                n_state = S_ID_MUL;
            end
            S_ID_MUL: begin
                if (r_l == '0) begin
                    n_id    = '0;
                    n_state = w_after_id;
                end else if (r_e == '0) begin
                    n_id    = ID_W'(PCT_FULL);
                    n_state = w_after_id;
                end else begin
                    n_a     = PROD_W'(r_l) * PROD_W'(MUL_ID_LEN);
                    n_b     = PROD_W'(r_e) * PROD_W'(MUL_ID_EDIT);
                    n_state = S_ID_SUB;
                end
            end
            S_ID_SUB: begin
                n_neg   = (r_a < r_b);
                n_mag   = (r_a < r_b) ? (r_b - r_a) : (r_a - r_b);
                n_state = S_ID_LD;
            end
            S_ID_LD: begin
                n_state = S_ID_WAIT;
            end
            S_ID_WAIT: begin
                if (w_div_rsp.done) begin
                    if (!r_neg) begin
                        n_id = (w_div_rsp.quo >= DIV_NUM_W'(PCT_FULL))
                               ? ID_W'(PCT_CAP) : ID_W'(w_div_rsp.quo);
                    end else begin
                        n_id = (w_div_rsp.quo > DIV_NUM_W'(PCT_FULL))
                               ? (ID_W'(0) - ID_W'(PCT_FULL))
                               : (ID_W'(0) - ID_W'(w_div_rsp.quo));
                    end
                    n_state = w_after_id;
                end
            end
            S_COV_D1: begin
                // query length less poly-A, floored at zero
                n_d     = (r_c0 > r_c1) ? (r_c0 - r_c1) : '0;
                n_state = S_COV_D2;
            end
            S_COV_D2: begin
                n_d     = (r_d > r_c2) ? (r_d - r_c2) : '0;
                n_state = S_COV_CHK;
            end
            S_COV_CHK: begin
                if (r_tot_cov == TOT_W'(r_d)) begin
                    n_cov   = COV_W'(PCT_FULL);
                    n_state = S_FIN;
                end else if (r_d == '0) begin
                    n_cov   = COV_W'(PCT_CAP);
                    n_state = S_FIN;
                end else begin
                    n_a     = PROD_W'(r_tot_cov) * PROD_W'(MUL_COV);
                    n_state = S_COV_LD;
                end
            end
            S_COV_LD: begin
                n_state = S_COV_WAIT;
            end
            S_COV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_cov   = (w_div_rsp.quo < DIV_NUM_W'(PCT_FULL))
                              ? COV_W'(w_div_rsp.quo) : COV_W'(PCT_CAP);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_o_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_cmd;
                    n_o_est   = '0;
                    n_o_gen   = '0;
                    n_o_id    = r_id;
                    if (r_cmd == CMD_RECORD) begin
                        n_o_match     = f_sat32(r_tot_matches);
                        n_o_both_n    = f_sat32(r_tot_both_n);
                        n_o_cov_cnt   = f_sat32(r_tot_cov);
                        n_o_cov_pct   = r_cov;
                        n_tot_edits   = '0;
                        n_tot_matches = '0;
                        n_tot_both_n  = '0;
                        n_tot_len     = '0;
                        n_tot_cov     = '0;
                    end else begin
                        n_o_match     = r_exon_matches;
                        n_o_both_n    = r_exon_both_n;
                        n_o_cov_cnt   = '0;
                        n_o_cov_pct   = '0;
                        n_tot_edits   = r_tot_edits + TOT_W'(r_exon_edits);
                        n_tot_matches = r_tot_matches + TOT_W'(r_exon_matches);
                        n_tot_both_n  = r_tot_both_n + TOT_W'(r_exon_both_n);
                        n_tot_len     = r_tot_len + r_l;
                        n_tot_cov     = r_tot_cov + TOT_W'(r_qs);
                    end
                    n_exon_edits   = '0;
                    n_exon_matches = '0;
                    n_exon_both_n  = '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_exon_edits   <= '0;
            r_exon_matches <= '0;
            r_exon_both_n  <= '0;
            r_tot_edits    <= '0;
            r_tot_matches  <= '0;
            r_tot_both_n   <= '0;
            r_tot_len      <= '0;
            r_tot_cov      <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_exon_edits   <= n_exon_edits;
            r_exon_matches <= n_exon_matches;
            r_exon_both_n  <= n_exon_both_n;
            r_tot_edits    <= n_tot_edits;
            r_tot_matches  <= n_tot_matches;
            r_tot_both_n   <= n_tot_both_n;
            r_tot_len      <= n_tot_len;
            r_tot_cov      <= n_tot_cov;
            r_o_valid      <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_c0        <= n_c0;
        r_c1        <= n_c1;
        r_c2        <= n_c2;
        r_c3        <= n_c3;
        r_gs        <= n_gs;
        r_qs        <= n_qs;
        r_l         <= n_l;
        r_e         <= n_e;
        r_a         <= n_a;
        r_b         <= n_b;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_d         <= n_d;
        r_id        <= n_id;
        r_cov       <= n_cov;
        r_o_kind    <= n_o_kind;
        r_o_est     <= n_o_est;
        r_o_gen     <= n_o_gen;
        r_o_match   <= n_o_match;
        r_o_both_n  <= n_o_both_n;
        r_o_id      <= n_o_id;
        r_o_cov_cnt <= n_o_cov_cnt;
        r_o_cov_pct <= n_o_cov_pct;
    end

    assign o_res.valid            = r_o_valid;
    assign o_res.result_kind      = r_o_kind;
    assign o_res.est_out          = r_o_est;
    assign o_res.gen_out          = r_o_gen;
    assign o_res.match_count      = r_o_match;
    assign o_res.both_n_count     = r_o_both_n;
    assign o_res.identity_percent = r_o_id;
    assign o_res.covered_count    = r_o_cov_cnt;
    assign o_res.coverage_percent = r_o_cov_pct;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_ID_WAIT || r_state == S_COV_WAIT))
        else $error("divider result arrived outside a wait step");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ($signed(o_res.identity_percent) >= -8'sd100
                         && $signed(o_res.identity_percent) <= 8'sd100))
        else $error("identity out of range");

    a_exon_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_o_free) |=>
            (r_exon_edits == '0 && r_exon_matches == '0 && r_exon_both_n == '0))
        else $error("exon counters not cleared after end beat");

endmodule
